// ----- sv/txcw_pkg.sv -----
// Shared constants, types and helper functions of the text console writer.
package txcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS = 24;
   localparam int CELLS = ROWS * COLUMNS;

   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int COL_W = $clog2(COLUMNS);

   localparam logic [ROW_W:0] ROW_LIM = ROWS[ROW_W:0];
   localparam logic [ADDR_W-1:0] COLS_ADDR = COLUMNS[ADDR_W-1:0];
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);

   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] SPACE_CODE = 8'd32;
   localparam logic [7:0] RESET_ATTR = 8'h07;
   localparam logic [15:0] BLANK_CELL = {RESET_ATTR, SPACE_CODE};

   localparam logic OP_PUT = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic clr_step;
      logic load;
      logic exec;
      logic blank_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic blank_last;
      logic scroll;
   } dp_stat_type;

   function automatic logic [4:0] to_rsp_row(input logic [ROW_W-1:0] r);
      logic [ROW_W+4:0] w;
      w = {5'd0, r};
      return w[4:0];
   endfunction

   function automatic logic [6:0] to_rsp_col(input logic [COL_W-1:0] c);
      logic [COL_W+6:0] w;
      w = {7'd0, c};
      return w[6:0];
   endfunction

   function automatic logic [ROW_W-1:0] from_req_row(input logic [4:0] r);
      logic [ROW_W+4:0] w;
      w = {{ROW_W{1'b0}}, r};
      return w[ROW_W-1:0];
   endfunction

   function automatic logic [COL_W-1:0] from_req_col(input logic [6:0] c);
      logic [COL_W+6:0] w;
      w = {{COL_W{1'b0}}, c};
      return w[COL_W-1:0];
   endfunction

endpackage

// ----- sv/text_console_writer_top.sv -----
// Top level of the text console writer: controller, datapath and ports.
//
//   channel  direction  beat marked by          payload
//   req      in         start && !busy          opcode, char_code, read_row, read_col
//   rsp      out        rsp_valid (one cycle)   cell_entry, cursor_row, cursor_col
//   csr      in         csr_valid && csr_ready  data (text attribute)
//
// Each item is handled in order: the request is captured, then the screen memory is accessed.
// A put that scrolls is followed by the blanking of the bottom row, one cell a cycle.
// After reset a clearing pass writes all ROWS*COLUMNS (1920) cells of the memory; busy is high.
// The circular row offset makes a scroll cost only the blanking of one row.
// The receiver cannot stall; each result beat is presented for exactly one cycle.
module text_console_writer_top
   import txcw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [4:0]  req_read_row,
   input  logic [6:0]  req_read_col,
   output logic        rsp_valid,
   output logic [15:0] rsp_cell_entry,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_col,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ready = 1'b1;

   txcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   txcw_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .csr_we         (csr_valid && csr_ready),
      .csr_data       (csr_data),
      .rsp_cell_entry (rsp_cell_entry),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col)
   );

endmodule

// ----- sv/txcw_ctrl.sv -----
// Controller state machine: clearing sweep, item execution and row blanking.
module txcw_ctrl
   import txcw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_BLANK
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.clr_step   = (state_ff == S_CLEAR);
      cmd.load       = (state_ff == S_IDLE) && start && !busy_ff;
      cmd.exec       = (state_ff == S_EXEC);
      cmd.blank_step = (state_ff == S_BLANK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_EXEC);
         unique case (state_ff)
            S_CLEAR: begin
               if (stat.clr_last) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_EXEC;
                  busy_ff  <= 1'b1;
               end
            end
            S_EXEC: begin
               if (stat.scroll) begin
                  state_ff <= S_BLANK;
               end else begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            S_BLANK: begin
               if (stat.blank_last) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_EXEC))
      else $error("result beat without an execute cycle");
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result beat lasted more than one cycle");
`endif

endmodule

// ----- sv/txcw_datapath.sv -----
// Datapath: screen memory, cursor, scroll offset, attribute and result data.
module txcw_datapath
   import txcw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   input  logic         req_opcode,
   input  logic [7:0]   req_char_code,
   input  logic [4:0]   req_read_row,
   input  logic [6:0]   req_read_col,
   input  logic         csr_we,
   input  logic [7:0]   csr_data,
   output logic [15:0]  rsp_cell_entry,
   output logic [4:0]   rsp_cursor_row,
   output logic [6:0]   rsp_cursor_col
);

   logic [15:0] mem [CELLS];

   logic             op_ff;
   logic [7:0]       char_ff;
   logic [ROW_W-1:0] rrow_ff;
   logic [COL_W-1:0] rcol_ff;
   logic             rok_ff;

   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  top_ff, top_in;
   logic [7:0]        attr_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] blank_addr_ff;
   logic [COL_W-1:0]  blank_col_ff;
   logic [15:0]       rd_data_ff;
   logic              cell_sel_ff;

   logic              is_nl, wrap, adv, scroll;
   logic [ROW_W-1:0]  sel_row;
   logic [COL_W-1:0]  sel_col;
   logic [ROW_W:0]    prow_sum;
   logic [ROW_W-1:0]  prow;
   logic [ADDR_W-1:0] prow_ext;
   logic [ADDR_W-1:0] exec_addr;
   logic [ADDR_W-1:0] top_ext;
   logic [ADDR_W-1:0] top_base;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [15:0]       wr_data;

   always_comb begin
      is_nl  = (char_ff == NEWLINE_CODE);
      wrap   = !is_nl && (cur_col_ff == LAST_COL);
      adv    = is_nl || wrap;
      scroll = (op_ff == OP_PUT) && adv && (cur_row_ff == LAST_ROW);

      cur_col_in = adv ? '0 : cur_col_ff + COL_W'(1);
      cur_row_in = (adv && !scroll) ? cur_row_ff + ROW_W'(1) : cur_row_ff;
      top_in     = (top_ff == LAST_ROW) ? '0 : top_ff + ROW_W'(1);

      sel_row  = (op_ff == OP_READ) ? rrow_ff : cur_row_ff;
      sel_col  = (op_ff == OP_READ) ? rcol_ff : cur_col_ff;
      prow_sum = {1'b0, top_ff} + {1'b0, sel_row};
      prow     = (prow_sum >= ROW_LIM) ? ROW_W'(prow_sum - ROW_LIM) : prow_sum[ROW_W-1:0];
      prow_ext = ADDR_W'(prow);
      exec_addr = ADDR_W'(prow_ext * COLS_ADDR) + ADDR_W'(sel_col);
      top_ext  = ADDR_W'(top_ff);
      top_base = ADDR_W'(top_ext * COLS_ADDR);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = exec_addr;
      wr_data = {attr_ff, char_ff};
      priority if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = BLANK_CELL;
      end else if (cmd.blank_step) begin
         wr_en   = 1'b1;
         wr_addr = blank_addr_ff;
         wr_data = {attr_ff, SPACE_CODE};
      end else if (cmd.exec && (op_ff == OP_PUT) && !is_nl) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.exec && (op_ff == OP_READ)) begin
         rd_data_ff <= mem[exec_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         top_ff      <= '0;
         attr_ff     <= RESET_ATTR;
         clr_addr_ff <= '0;
         cell_sel_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            attr_ff <= csr_data;
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         if (cmd.exec) begin
            cell_sel_ff <= (op_ff == OP_READ) && rok_ff;
            if (op_ff == OP_PUT) begin
               cur_row_ff <= cur_row_in;
               cur_col_ff <= cur_col_in;
               if (scroll) begin
                  top_ff <= top_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         char_ff <= req_char_code;
         rrow_ff <= from_req_row(req_read_row);
         rcol_ff <= from_req_col(req_read_col);
         rok_ff  <= (32'(req_read_row) < ROWS) && (32'(req_read_col) < COLUMNS);
      end
      if (cmd.exec) begin
         blank_addr_ff <= top_base;
         blank_col_ff  <= '0;
      end else if (cmd.blank_step) begin
         blank_addr_ff <= blank_addr_ff + ADDR_W'(1);
         blank_col_ff  <= blank_col_ff + COL_W'(1);
      end
   end

   always_comb begin
      stat            = '0;
      stat.clr_last   = (clr_addr_ff == LAST_CELL);
      stat.blank_last = (blank_col_ff == LAST_COL);
      stat.scroll     = scroll;
   end

   assign rsp_cell_entry = cell_sel_ff ? rd_data_ff : 16'd0;
   assign rsp_cursor_row = to_rsp_row(cur_row_ff);
   assign rsp_cursor_col = to_rsp_col(cur_col_ff);

`ifndef ASSERT_OFF
   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      (32'(cur_row_ff) < ROWS) && (32'(cur_col_ff) < COLUMNS))
      else $error("cursor left the grid");
   a_scroll_keeps_bottom: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && scroll) |=> (cur_row_ff == LAST_ROW) && (cur_col_ff == '0))
      else $error("scroll did not leave the cursor at the bottom row start");
`endif

endmodule

// ----- tb/tb_text_console_writer_top.sv -----
// Self-checking testbench for the text console writer: puts, reads and attribute writes.
module tb_text_console_writer_top;
   import txcw_pkg::*;

   localparam int unsigned RUN_LIMIT_CYCLES = 500000;
   localparam int unsigned RANDOM_PHASES = 5;
   localparam int unsigned PHASE_ITEMS = 150;

   typedef struct {
      logic       opcode;
      logic [7:0] char_code;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } console_req_type;

   typedef struct {
      logic [15:0] cell_entry;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
   } console_report_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [7:0]  req_char_code;
   logic [4:0]  req_read_row;
   logic [6:0]  req_read_col;
   logic        rsp_valid;
   logic [15:0] rsp_cell_entry;
   logic [4:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_col;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   logic [15:0]        screen_model [CELLS];
   int unsigned        model_row;
   int unsigned        model_col;
   logic [7:0]         text_attr;
   console_report_type console_reports_q [$];

   logic        req_held;
   int unsigned pending_gap;
   int unsigned gap_mode;
   int unsigned line_left;
   int unsigned mismatches;
   int unsigned items_sent;
   int unsigned reads_done;
   int unsigned newlines_done;
   int unsigned wraps_done;
   int unsigned scrolls_done;
   int unsigned attr_writes;

   text_console_writer_top u_top (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_read_row   (req_read_row),
      .req_read_col   (req_read_col),
      .rsp_valid      (rsp_valid),
      .rsp_cell_entry (rsp_cell_entry),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always #6 clock = ~clock;

   function automatic void advance_model_row();
      model_row++;
      if (model_row >= ROWS) begin
         for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_model[i] = screen_model[i + COLUMNS];
         end
         for (int c = 0; c < COLUMNS; c++) begin
            screen_model[(ROWS - 1) * COLUMNS + c] = {text_attr, SPACE_CODE};
         end
         model_row = ROWS - 1;
         scrolls_done++;
      end
   endfunction

   function automatic console_report_type predict_console(input console_req_type rq);
      console_report_type rs;
      rs.cell_entry = '0;
      if (rq.opcode == OP_READ) begin
         if (rq.read_row < ROWS && rq.read_col < COLUMNS)
            rs.cell_entry = screen_model[int'(rq.read_row) * COLUMNS + int'(rq.read_col)];
         reads_done++;
      end else if (rq.char_code == NEWLINE_CODE) begin
         model_col = 0;
         advance_model_row();
         newlines_done++;
      end else begin
         screen_model[model_row * COLUMNS + model_col] = {text_attr, rq.char_code};
         model_col++;
         if (model_col >= COLUMNS) begin
            model_col = 0;
            wraps_done++;
            advance_model_row();
         end
      end
      rs.cursor_row = 5'(model_row);
      rs.cursor_col = 7'(model_col);
      return rs;
   endfunction

   function automatic int unsigned draw_gap();
      case (gap_mode)
         0: return $urandom_range(0, 18);
         1: return 0;
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
      endcase
   endfunction

   task automatic send_request(input logic op, input logic [7:0] ch, input logic [4:0] rr,
                               input logic [6:0] rc);
      console_req_type item;
      repeat (pending_gap) @(posedge clock);
      start <= 1'b1;
      req_held = 1'b1;
      req_opcode <= op;
      req_char_code <= ch;
      req_read_row <= rr;
      req_read_col <= rc;
      do @(posedge clock); while (busy);
      item.opcode = op;
      item.char_code = ch;
      item.read_row = rr;
      item.read_col = rc;
      console_reports_q.push_back(predict_console(item));
      items_sent++;
      pending_gap = draw_gap();
      if (pending_gap != 0) begin
         start <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic put_char(input logic [7:0] ch);
      send_request(OP_PUT, ch, 5'($urandom), 7'($urandom));
   endtask

   task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
      send_request(OP_READ, 8'($urandom), rr, rc);
   endtask

   task automatic drain_results();
      if (req_held) begin
         start <= 1'b0;
         req_held = 1'b0;
         @(posedge clock);
      end
      while (console_reports_q.size() != 0) @(posedge clock);
   endtask

   task automatic settle_console();
      drain_results();
      repeat (COLUMNS + 8) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_text_attribute(input logic [7:0] attr);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= attr;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      text_attr = attr;
      attr_writes++;
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("ERROR %0t: %s expected %h, got %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      console_report_type want;
      if (!reset && rsp_valid) begin
         if (console_reports_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR %0t: result beat with nothing expected (cell %h, cursor %0d,%0d)",
                        $time, rsp_cell_entry, rsp_cursor_row, rsp_cursor_col);
         end else begin
            want = console_reports_q.pop_front();
            check_field("cell_entry", want.cell_entry, rsp_cell_entry);
            check_field("cursor_row", 16'(want.cursor_row), 16'(rsp_cursor_row));
            check_field("cursor_col", 16'(want.cursor_col), 16'(rsp_cursor_col));
         end
      end
   end

   task automatic test_reset_contents();
      read_cell(5'd0, 7'd0);
      read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
      read_cell(5'd11, 7'd40);
   endtask

   task automatic test_character_extremes();
      put_char(8'h00);
      put_char(8'hFF);
      put_char(8'h80);
      put_char(8'h7F);
      read_cell(5'd0, 7'd0);
      read_cell(5'd0, 7'd1);
      read_cell(5'd0, 7'd3);
      put_char(NEWLINE_CODE);
      read_cell(5'd0, 7'd4);
      read_cell(5'(ROWS), 7'd0);
      read_cell(5'd0, 7'(COLUMNS));
      read_cell(5'h1F, 7'h7F);
      read_cell(5'(ROWS - 1), 7'(COLUMNS));
   endtask

   task automatic test_attribute_extremes();
      settle_console();
      write_text_attribute(8'hFF);
      put_char(8'h41);
      settle_console();
      write_text_attribute(8'h00);
      put_char(8'h42);
      put_char(NEWLINE_CODE);
      read_cell(5'd1, 7'd0);
      read_cell(5'd1, 7'd1);
   endtask

   task automatic test_sender_pause();
      gap_mode = 1;
      for (int i = 0; i < 8; i++) begin
         if (i % 2 == 0) put_char(NEWLINE_CODE);
         else put_char(8'($urandom_range(33, 126)));
      end
      drain_results();
      for (int i = 0; i < 8; i++) begin
         read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, 9)));
      end
   endtask

   task automatic send_random_item();
      int unsigned sel;
      int unsigned len_sel;
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
         if (line_left == 0) begin
            put_char(NEWLINE_CODE);
            len_sel = $urandom_range(0, 99);
            if (len_sel < 50) line_left = 0;
            else if (len_sel < 70) line_left = $urandom_range(1, 6);
            else if (len_sel < 90) line_left = $urandom_range(7, 79);
            else line_left = $urandom_range(80, 96);
         end else begin
            put_char(8'($urandom_range(0, 255)));
            line_left--;
         end
      end else if (sel < 88) begin
         read_cell(5'(model_row), 7'($urandom_range(0, COLUMNS - 1)));
      end else if (sel < 96) begin
         read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
      end else begin
         read_cell(5'($urandom), 7'($urandom));
      end
   endtask

   task automatic test_random_traffic();
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_console();
         write_text_attribute((phase == RANDOM_PHASES - 1) ? RESET_ATTR : 8'($urandom));
         gap_mode = phase % 3;
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) send_random_item();
      end
   endtask

   initial begin
      repeat (RUN_LIMIT_CYCLES) @(posedge clock);
      $display("Timeout after %0d cycles with %0d results outstanding.",
               RUN_LIMIT_CYCLES, console_reports_q.size());
      $display("tb_text_console_writer_top failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_PUT;
      req_char_code = '0;
      req_read_row = '0;
      req_read_col = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      for (int i = 0; i < CELLS; i++) screen_model[i] = BLANK_CELL;
      model_row = 0;
      model_col = 0;
      text_attr = RESET_ATTR;
      req_held = 1'b0;
      pending_gap = 0;
      gap_mode = 0;
      line_left = 0;
      mismatches = 0;
      items_sent = 0;
      reads_done = 0;
      newlines_done = 0;
      wraps_done = 0;
      scrolls_done = 0;
      attr_writes = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_character_extremes();
      test_attribute_extremes();
      test_sender_pause();
      test_random_traffic();

      drain_results();
      repeat (COLUMNS + 16) @(posedge clock);
      if (console_reports_q.size() != 0) begin
         mismatches++;
         $display("ERROR: %0d expected results never arrived", console_reports_q.size());
      end
      $display("Sent %0d items: %0d reads, %0d newlines, %0d line wraps, %0d scrolls.",
               items_sent, reads_done, newlines_done, wraps_done, scrolls_done);
      $display("Wrote the text attribute %0d times; %0d mismatches.", attr_writes, mismatches);
      if (mismatches == 0) begin
         $display("tb_text_console_writer_top passed");
      end else begin
         $display("tb_text_console_writer_top failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/txcw_pkg.sv
sv/txcw_ctrl.sv
sv/txcw_datapath.sv
sv/text_console_writer_top.sv
tb/tb_text_console_writer_top.sv
